@@ rtl/core/prs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power rail sequencer package
// Shared types, widths, command and register codes, and the domain mask helper.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int NUM_STEPS = 5;
    localparam int RAIL_BITS = 6;
    localparam int STEP_W    = 3;
    localparam int TIMER_W   = 10;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_ON    = 2'd1,
        REQ_OFF   = 2'd2,
        REQ_CYCLE = 2'd3
    } req_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETTLE   = 3'd0,
        CFG_INTERVAL = 3'd1,
        CFG_LIMIT    = 3'd2,
        CFG_HOLD     = 3'd3,
        CFG_RELEASE  = 3'd4
    } cfg_code_t;

    typedef enum logic [6:0] {
        PH_IDLE       = 7'b0000001,
        PH_ON_SETTLE  = 7'b0000010,
        PH_ON_POLL    = 7'b0000100,
        PH_ON_RELEASE = 7'b0001000,
        PH_OFF_SETTLE = 7'b0010000,
        PH_OFF_POLL   = 7'b0100000,
        PH_CYCLE_HOLD = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [RAIL_BITS-1:0] rail_enables;
        logic                 cpu_reset;
        logic                 busy_res;
        logic                 done_res;
        logic                 timed_out;
        logic [STEP_W-1:0]    failed_step;
        logic                 cmd_rejected;
    } res_t;

    // Domain 0 drives LPD and MIO together; every later domain owns one rail.
    function automatic logic [RAIL_BITS-1:0] dom_mask(input logic [STEP_W-1:0] d);
        logic [RAIL_BITS-1:0] m;
        if (d == '0)
        begin
            m = RAIL_BITS'(3);
        end
        else
        begin
            m = RAIL_BITS'(1) << ({1'b0, d} + (STEP_W+1)'(1));
        end
        return m;
    endfunction

    function automatic logic [TIMER_W-1:0] load_delay(input logic [TIMER_W-1:0] t);
        return (t == '0) ? '0 : t - TIMER_W'(1);
    endfunction

endpackage

@@ rtl/core/prs_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one command beat: request code and the sampled power-good bits.
// ----------------------------------------------------------------------------
interface prs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [5:0] rails_good;

    modport source (output valid, output req_type, output rails_good, input ready);
    modport sink   (input valid, input req_type, input rails_good, output ready);
endinterface

@@ rtl/core/prs_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel interface
// Carries one status beat per request: drives, reset line and sequence flags.
// ----------------------------------------------------------------------------
interface prs_res_if;
    logic       valid;
    logic       ready;
    logic [5:0] rail_enables;
    logic       cpu_reset;
    logic       busy_res;
    logic       done_res;
    logic       timed_out;
    logic [2:0] failed_step;
    logic       cmd_rejected;

    modport source (output valid, output rail_enables, output cpu_reset, output busy_res,
                    output done_res, output timed_out, output failed_step,
                    output cmd_rejected, input ready);
    modport sink   (input valid, input rail_enables, input cpu_reset, input busy_res,
                    input done_res, input timed_out, input failed_step,
                    input cmd_rejected, output ready);
endinterface

@@ rtl/core/power_rail_sequencer_top.sv @@
`timescale 1ns / 1ps
// The result beat for a request is registered and valid in the cycle after it is taken.
// Throughput: one request per cycle unless res stalls; the sequencer state and result
// register update in one pass; the result register frees on the cycle it is drained.
// Reset: all rails off, processor reset asserted, sequencer idle, registers at defaults.
// ----------------------------------------------------------------------------
// Power rail sequencer top level
// Steps five power domains up or down on tick beats and manages the CPU reset.
// ----------------------------------------------------------------------------
module power_rail_sequencer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [prs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [prs_pkg::CFG_DAT_W-1:0] cfg_data,
    prs_req_if.sink                       req,
    prs_res_if.source                     res
);
    import prs_pkg::*;

    logic [TIMER_W-1:0]   settle_reg;
    logic [COUNT_W-1:0]   interval_reg;
    logic [COUNT_W-1:0]   limit_reg;
    logic [TIMER_W-1:0]   hold_reg;
    logic [COUNT_W-1:0]   release_reg;

    phase_t               phase_reg,  phase_next;
    logic [STEP_W-1:0]    step_reg,   step_next;
    logic [TIMER_W-1:0]   timer_reg,  timer_next;
    logic [COUNT_W-1:0]   pcnt_reg,   pcnt_next;
    logic [RAIL_BITS-1:0] en_reg,     en_next;
    logic                 rline_reg,  rline_next;
    logic [STEP_W-1:0]    failed_reg, failed_next;

    res_t                 res_reg,    res_next;
    logic                 res_valid_reg;

    logic                 acc;
    logic                 chk_off;
    logic                 start;
    logic                 start_off;
    logic                 ok;
    logic                 done_f;
    logic                 tout_f;
    logic [STEP_W-1:0]    cur_dom;
    logic [STEP_W-1:0]    start_dom;
    logic [RAIL_BITS-1:0] cur_mask;
    logic [RAIL_BITS-1:0] start_mask;
    logic [COUNT_W-1:0]   lim;
    logic [COUNT_W-1:0]   pcnt_inc;

    assign req.ready = !res_valid_reg || res.ready;
    assign acc       = req.valid && req.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg   <= TIMER_W'(100);
            interval_reg <= COUNT_W'(10);
            limit_reg    <= COUNT_W'(100);
            hold_reg     <= TIMER_W'(100);
            release_reg  <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SETTLE:   settle_reg   <= cfg_data;
                CFG_INTERVAL: interval_reg <= cfg_data[COUNT_W-1:0];
                CFG_LIMIT:    limit_reg    <= cfg_data[COUNT_W-1:0];
                CFG_HOLD:     hold_reg     <= cfg_data;
                CFG_RELEASE:  release_reg  <= cfg_data[COUNT_W-1:0];
                default:      ;
            endcase
        end
    end

    assign chk_off  = (phase_reg == PH_OFF_SETTLE) || (phase_reg == PH_OFF_POLL);
    assign cur_dom  = chk_off ? (STEP_W'(NUM_STEPS - 1) - step_reg) : step_reg;
    assign cur_mask = dom_mask(cur_dom);
    assign ok       = chk_off ? ((req.rails_good & cur_mask) == '0)
                              : ((req.rails_good & cur_mask) == cur_mask);
    assign lim      = (limit_reg == '0) ? COUNT_W'(1) : limit_reg;
    assign pcnt_inc = pcnt_reg + COUNT_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        step_next   = step_reg;
        timer_next  = timer_reg;
        pcnt_next   = pcnt_reg;
        en_next     = en_reg;
        rline_next  = rline_reg;
        failed_next = failed_reg;
        done_f      = 1'b0;
        tout_f      = 1'b0;
        start       = 1'b0;
        start_off   = 1'b0;
        res_next    = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (req.req_type == REQ_ON || req.req_type == REQ_OFF)
                begin
                    start     = 1'b1;
                    start_off = (req.req_type == REQ_OFF);
                    step_next = '0;
                end
                else if (req.req_type == REQ_CYCLE)
                begin
                    rline_next = 1'b1;
                    timer_next = load_delay(hold_reg);
                    phase_next = PH_CYCLE_HOLD;
                end
            end
            PH_ON_SETTLE, PH_ON_POLL, PH_OFF_SETTLE, PH_OFF_POLL:
            begin
                if (timer_reg != '0)
                begin
                    timer_next = timer_reg - TIMER_W'(1);
                end
                else if (ok)
                begin
                    if ({1'b0, step_reg} + (STEP_W+1)'(1) < (STEP_W+1)'(NUM_STEPS))
                    begin
                        step_next = step_reg + STEP_W'(1);
                        start     = 1'b1;
                        start_off = chk_off;
                    end
                    else if (chk_off)
                    begin
                        rline_next = 1'b1;
                        done_f     = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        timer_next = load_delay({2'b00, release_reg});
                        phase_next = PH_ON_RELEASE;
                    end
                end
                else
                begin
                    pcnt_next = pcnt_inc;
                    if (pcnt_inc >= lim)
                    begin
                        failed_next = step_reg;
                        tout_f      = 1'b1;
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        timer_next = load_delay({2'b00, interval_reg});
                        phase_next = chk_off ? PH_OFF_POLL : PH_ON_POLL;
                    end
                end
            end
            PH_ON_RELEASE, PH_CYCLE_HOLD:
            begin
                if (timer_reg != '0)
                begin
                    timer_next = timer_reg - TIMER_W'(1);
                end
                else
                begin
                    rline_next = 1'b0;
                    done_f     = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // Opening a domain step: drive or drop its rails and start the settle wait.
        start_dom  = start_off ? (STEP_W'(NUM_STEPS - 1) - step_next) : step_next;
        start_mask = dom_mask(start_dom);
        if (start)
        begin
            en_next    = start_off ? (en_reg & ~start_mask) : (en_reg | start_mask);
            timer_next = load_delay(settle_reg);
            pcnt_next  = '0;
            phase_next = start_off ? PH_OFF_SETTLE : PH_ON_SETTLE;
        end

        res_next.rail_enables = en_next;
        res_next.cpu_reset    = rline_next;
        res_next.busy_res     = (phase_next != PH_IDLE);
        res_next.done_res     = done_f;
        res_next.timed_out    = tout_f;
        res_next.failed_step  = failed_next;
        res_next.cmd_rejected = (phase_reg != PH_IDLE) && (req.req_type != REQ_TICK);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            step_reg      <= '0;
            timer_reg     <= '0;
            pcnt_reg      <= '0;
            en_reg        <= '0;
            rline_reg     <= 1'b1;
            failed_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                phase_reg     <= phase_next;
                step_reg      <= step_next;
                timer_reg     <= timer_next;
                pcnt_reg      <= pcnt_next;
                en_reg        <= en_next;
                rline_reg     <= rline_next;
                failed_reg    <= failed_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.rail_enables = res_reg.rail_enables;
    assign res.cpu_reset    = res_reg.cpu_reset;
    assign res.busy_res     = res_reg.busy_res;
    assign res.done_res     = res_reg.done_res;
    assign res.timed_out    = res_reg.timed_out;
    assign res.failed_step  = res_reg.failed_step;
    assign res.cmd_rejected = res_reg.cmd_rejected;

    // A beat cannot report success and timeout together.
    a_done_xor_tout: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_reg.done_res && res_reg.timed_out))
        else $error("done and timeout reported in the same beat");

    // A tick while idle keeps the sequencer idle.
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && phase_reg == PH_IDLE && req.req_type == REQ_TICK) |=> phase_reg == PH_IDLE)
        else $error("idle tick left the idle phase");

    // A command taken while idle is never flagged as rejected.
    a_no_reject_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && phase_reg == PH_IDLE) |=> !res_reg.cmd_rejected)
        else $error("command rejected while idle");

    // Sequencer state only moves on an accepted beat.
    a_timer_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !acc |=> ($stable(timer_reg) && $stable(en_reg) && $stable(phase_reg)))
        else $error("sequencer state changed without a request beat");

    // The check count never exceeds the effective poll limit.
    a_pcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ON_POLL || phase_reg == PH_OFF_POLL) |-> pcnt_reg < lim)
        else $error("poll count ran past the limit");

endmodule

@@ tb/sv/power_rail_sequencer_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Power rail sequencer testbench
// Sends request beats under random flow control on both channels. A behavioral
// copy of the sequencer predicts every beat not fixed by a directed row; beats
// are compared field by field. A short directed table runs first, then random stages.
// ----------------------------------------------------------------------------
module power_rail_sequencer_top_test;
    import prs_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 7;
    localparam int STAGES          = 12;
    localparam int STAGE_SLOW      = 2;
    localparam int STAGE_LONG_POLL = 5;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int PRINT_CAP       = 100;
    localparam int PLAN_ROWS       = 25;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct {
        bit                   zero_regs;
        req_code_t            rq;
        logic [RAIL_BITS-1:0] good;
        bit                   typed;
        res_t                 want;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    prs_req_if req_ch ();
    prs_res_if res_ch ();

    power_rail_sequencer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch.sink),
        .res       (res_ch.source)
    );

    // Mirror of the sequencer state and its registers.
    phase_t               seq_phase = PH_IDLE;
    int unsigned          seq_step = 0;
    int unsigned          seq_timer = 0;
    int unsigned          seq_polls = 0;
    logic [RAIL_BITS-1:0] seq_rails = '0;
    logic                 seq_reset = 1'b1;
    logic [STEP_W-1:0]    seq_failed = '0;
    int unsigned          reg_val [5] = '{100, 10, 100, 100, 1};

    res_t        status_due [$];
    res_t        due;
    int unsigned mismatch_count = 0;
    int unsigned beat_no = 0;
    int unsigned src_gap_pct = 28;
    int unsigned sink_gap_pct = 82;
    bit          rails_noisy = 1'b0;
    int unsigned stuck_step = NUM_STEPS;

    plan_row_t plan [PLAN_ROWS] = '{
        '{1'b0, REQ_TICK,  6'h00, 1'b1, '{6'h00, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0}},
        '{1'b0, REQ_TICK,  6'h3F, 1'b1, '{6'h00, 1'b1, 1'b0, 1'b0, 1'b0, 3'd0, 1'b0}},
        '{1'b0, REQ_CYCLE, 6'h3F, 1'b1, '{6'h00, 1'b1, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0}},
        '{1'b1, REQ_ON,    6'h3F, 1'b1, '{6'h03, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0}},
        '{1'b0, REQ_OFF,   6'h3F, 1'b1, '{6'h07, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 1'b1}},
        '{1'b0, REQ_CYCLE, 6'h0F, 1'b1, '{6'h0F, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 1'b1}},
        '{1'b0, REQ_TICK,  6'h0F, 1'b1, '{6'h1F, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0}},
        '{1'b0, REQ_TICK,  6'h0F, 1'b1, '{6'h1F, 1'b0, 1'b0, 1'b0, 1'b1, 3'd3, 1'b0}},
        '{1'b0, REQ_OFF,   6'h3F, 1'b1, '{6'h1F, 1'b0, 1'b1, 1'b0, 1'b0, 3'd3, 1'b0}},
        '{1'b0, REQ_TICK,  6'h3F, 1'b1, '{6'h1F, 1'b0, 1'b0, 1'b0, 1'b1, 3'd0, 1'b0}},
        '{1'b0, REQ_ON,    6'h3F, 1'b1, '{6'h1F, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 1'b0}},
        '{1'b0, REQ_TICK,  6'h3F, 1'b0, '0},
        '{1'b0, REQ_TICK,  6'h3F, 1'b0, '0},
        '{1'b0, REQ_TICK,  6'h3F, 1'b0, '0},
        '{1'b0, REQ_TICK,  6'h3F, 1'b0, '0},
        '{1'b0, REQ_TICK,  6'h3F, 1'b0, '0},
        '{1'b0, REQ_TICK,  6'h3F, 1'b1, '{6'h3F, 1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 1'b0}},
        '{1'b0, REQ_OFF,   6'h00, 1'b0, '0},
        '{1'b0, REQ_TICK,  6'h00, 1'b0, '0},
        '{1'b0, REQ_TICK,  6'h00, 1'b0, '0},
        '{1'b0, REQ_TICK,  6'h00, 1'b0, '0},
        '{1'b0, REQ_TICK,  6'h00, 1'b0, '0},
        '{1'b0, REQ_TICK,  6'h00, 1'b1, '{6'h00, 1'b1, 1'b0, 1'b1, 1'b0, 3'd0, 1'b0}},
        '{1'b0, REQ_CYCLE, 6'h00, 1'b0, '0},
        '{1'b0, REQ_TICK,  6'h3F, 1'b1, '{6'h00, 1'b0, 1'b0, 1'b1, 1'b0, 3'd0, 1'b0}}
    };

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(0, 99) >= sink_gap_pct);
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
        begin
            report_mismatch($sformatf("beat %0d %s: got %0d, expected %0d",
                                      beat_no, name, got, want));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            beat_no++;
            if (status_due.size() == 0)
            begin
                report_mismatch($sformatf("beat %0d arrived with nothing outstanding",
                                          beat_no));
            end
            else
            begin
                due = status_due.pop_front();
                compare_field("rail_enables", 32'(res_ch.rail_enables),
                              32'(due.rail_enables));
                compare_field("cpu_reset", 32'(res_ch.cpu_reset), 32'(due.cpu_reset));
                compare_field("busy_res", 32'(res_ch.busy_res), 32'(due.busy_res));
                compare_field("done_res", 32'(res_ch.done_res), 32'(due.done_res));
                compare_field("timed_out", 32'(res_ch.timed_out), 32'(due.timed_out));
                compare_field("failed_step", 32'(res_ch.failed_step),
                              32'(due.failed_step));
                compare_field("cmd_rejected", 32'(res_ch.cmd_rejected),
                              32'(due.cmd_rejected));
            end
        end
    end

    // Domain 0 is LPD and MIO together; domain d above zero owns rail d+1.
    function automatic logic [RAIL_BITS-1:0] domain_rails(input int unsigned d);
        return (d == 0) ? RAIL_BITS'(3) : RAIL_BITS'(1 << (d + 1));
    endfunction

    function automatic int unsigned delay_load(input int unsigned ticks);
        return (ticks == 0) ? 0 : ticks - 1;
    endfunction

    // Power-off walks the domains from the top down.
    function automatic int unsigned live_domain(input bit off);
        return off ? NUM_STEPS - 1 - seq_step : seq_step;
    endfunction

    task automatic open_domain(input bit off);
        logic [RAIL_BITS-1:0] m;
        m = domain_rails(live_domain(off));
        seq_rails = off ? (seq_rails & ~m) : (seq_rails | m);
        seq_timer = delay_load(reg_val[CFG_SETTLE]);
        seq_polls = 0;
        seq_phase = off ? PH_OFF_SETTLE : PH_ON_SETTLE;
    endtask

    task automatic probe_domain(input bit off, input logic [RAIL_BITS-1:0] good,
                                inout bit done, inout bit tout);
        logic [RAIL_BITS-1:0] m;
        bit                   settled;
        int unsigned          tries;
        m = domain_rails(live_domain(off));
        settled = off ? ((good & m) == '0) : ((good & m) == m);
        tries = (reg_val[CFG_LIMIT] == 0) ? 1 : reg_val[CFG_LIMIT];
        if (settled)
        begin
            if (seq_step + 1 < NUM_STEPS)
            begin
                seq_step++;
                open_domain(off);
            end
            else if (off)
            begin
                seq_reset = 1'b1;
                done = 1'b1;
                seq_phase = PH_IDLE;
            end
            else
            begin
                seq_timer = delay_load(reg_val[CFG_RELEASE]);
                seq_phase = PH_ON_RELEASE;
            end
        end
        else
        begin
            seq_polls++;
            if (seq_polls >= tries)
            begin
                seq_failed = STEP_W'(seq_step);
                tout = 1'b1;
                seq_phase = PH_IDLE;
            end
            else
            begin
                seq_timer = delay_load(reg_val[CFG_INTERVAL]);
                seq_phase = off ? PH_OFF_POLL : PH_ON_POLL;
            end
        end
    endtask

    task automatic step_sequencer(input req_code_t rq, input logic [RAIL_BITS-1:0] good,
                                  output res_t r);
        bit done;
        bit tout;
        bit rej;
        done = 1'b0;
        tout = 1'b0;
        rej = 1'b0;
        if (seq_phase == PH_IDLE)
        begin
            if (rq == REQ_ON || rq == REQ_OFF)
            begin
                seq_step = 0;
                open_domain(rq == REQ_OFF);
            end
            else if (rq == REQ_CYCLE)
            begin
                seq_reset = 1'b1;
                seq_timer = delay_load(reg_val[CFG_HOLD]);
                seq_phase = PH_CYCLE_HOLD;
            end
        end
        else
        begin
            // A command while busy is dropped, but the sequence still moves on.
            rej = (rq != REQ_TICK);
            if (seq_timer != 0)
            begin
                seq_timer--;
            end
            else
            begin
                case (seq_phase)
                    PH_ON_SETTLE, PH_ON_POLL:   probe_domain(1'b0, good, done, tout);
                    PH_OFF_SETTLE, PH_OFF_POLL: probe_domain(1'b1, good, done, tout);
                    default:
                    begin
                        // End of the release delay or of the reset hold.
                        seq_reset = 1'b0;
                        done = 1'b1;
                        seq_phase = PH_IDLE;
                    end
                endcase
            end
        end
        r.rail_enables = seq_rails;
        r.cpu_reset    = seq_reset;
        r.busy_res     = (seq_phase != PH_IDLE);
        r.done_res     = done;
        r.timed_out    = tout;
        r.failed_step  = seq_failed;
        r.cmd_rejected = rej;
    endtask

    task automatic send_request(input req_code_t rq, input logic [RAIL_BITS-1:0] good,
                                input bit typed, input res_t typed_res);
        res_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rq;
        req_ch.rails_good <= good;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        step_sequencer(rq, good, predicted);
        status_due.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (status_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic program_regs(input int unsigned vals [5]);
        int        i;
        cfg_code_t idx;
        wait_drained();
        for (i = 0; i < 5; i++)
        begin
            idx = cfg_code_t'(i);
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            if (idx == CFG_SETTLE || idx == CFG_HOLD)
            begin
                cfg_data   <= CFG_DAT_W'(vals[i]);
                reg_val[i] = vals[i] & 32'h3FF;
            end
            else
            begin
                // The upper data bits are junk for the 8-bit registers.
                cfg_data   <= {2'($urandom), 8'(vals[i])};
                reg_val[i] = vals[i] & 32'hFF;
            end
        end
        // A write past the register list must leave everything as it is.
        @(negedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= CFG_DAT_W'($urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_beat(input bit ticks_only);
        req_code_t            rq;
        logic [RAIL_BITS-1:0] good;
        logic [RAIL_BITS-1:0] m;
        bit                   off;
        bit                   raise;
        int unsigned          pick;
        pick = $urandom_range(0, 99);
        if (ticks_only)
        begin
            rq = REQ_TICK;
        end
        else if (seq_phase == PH_IDLE)
        begin
            rq = (pick < 35) ? REQ_ON : (pick < 65) ? REQ_OFF :
                 (pick < 85) ? REQ_CYCLE : REQ_TICK;
            // Decide how the rails behave for the sequence about to start.
            pick = $urandom_range(0, 99);
            rails_noisy = (pick >= 85);
            stuck_step = (pick >= 70 && pick < 85) ? $urandom_range(0, NUM_STEPS - 1)
                                                   : NUM_STEPS;
        end
        else
        begin
            rq = (pick < 3) ? REQ_ON : (pick < 5) ? REQ_OFF :
                 (pick < 8) ? REQ_CYCLE : REQ_TICK;
        end
        good = RAIL_BITS'($urandom);
        if (!rails_noisy && $urandom_range(0, 99) >= 3)
        begin
            off = (seq_phase == PH_OFF_SETTLE || seq_phase == PH_OFF_POLL);
            m = domain_rails(live_domain(off));
            raise = (seq_step == stuck_step) ? off : !off;
            good = raise ? (good | m) : (good & ~m);
        end
        send_request(rq, good, 1'b0, '0);
    endtask

    initial
    begin
        int          s;
        int          n;
        int          guard;
        int unsigned settings [5];
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_TICK;
        req_ch.rails_good = '0;
        res_ch.ready      = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].zero_regs)
            begin
                while (seq_phase != PH_IDLE)
                begin
                    random_beat(1'b1);
                end
                program_regs('{0, 0, 0, 0, 0});
            end
            send_request(plan[i].rq, plan[i].good, plan[i].typed, plan[i].want);
        end

        for (s = 0; s < STAGES; s++)
        begin
            if (s == STAGES / 3)
            begin
                src_gap_pct = 82;
                sink_gap_pct = 28;
            end
            else if (s == 2 * STAGES / 3)
            begin
                src_gap_pct = 0;
                sink_gap_pct = 0;
            end
            case (s)
                STAGE_SLOW:      settings = '{40, 255, 2, 1023, 255};
                STAGE_LONG_POLL: settings = '{1, 1, 255, 1, 1};
                default:         settings = '{$urandom_range(0, 6), $urandom_range(0, 4),
                                              $urandom_range(0, 5), $urandom_range(0, 8),
                                              $urandom_range(0, 4)};
            endcase
            program_regs(settings);
            // The long-delay stages start only a few sequences.
            n = (s == STAGE_SLOW || s == STAGE_LONG_POLL) ? 4 : $urandom_range(50, 90);
            repeat (n)
            begin
                if ($urandom_range(0, 99) < 2)
                begin
                    wait_drained();
                end
                random_beat(1'b0);
            end
            while (seq_phase != PH_IDLE)
            begin
                random_beat(1'b1);
            end
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        guard = 0;
        while (status_due.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        if (status_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d status beats never arrived", status_due.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
